// ===== rtl/zms_pkg.sv =====
// zms_pkg: types and constants shared by the zipmap stream parser
// item structs, parser phase codes, special byte values and error codes
// no dependencies
`default_nettype none

package zms_pkg;

    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] BIG_PREFIX = 8'hFD;
    localparam logic [7:0] BAD_PREFIX = 8'hFE;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_PREFIX = 2'd1;
    localparam logic [1:0] ERR_AFTER_END  = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_PREFIX     = 7'b0000010,
        PH_LEN_EXT    = 7'b0000100,
        PH_FREE_COUNT = 7'b0001000,
        PH_DATA       = 7'b0010000,
        PH_FREE_SKIP  = 7'b0100000,
        PH_DONE       = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_map;
    } zms_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_value;
        logic        last_of_string;
        logic        empty_string;
        logic        map_end;
        logic [31:0] pair_count;
        logic [1:0]  error_code;
    } zms_out_t;

endpackage

`default_nettype wire

// ===== rtl/zms_parse_core.sv =====
// zms_parse_core: parser state registers and next-state / result logic
// one accepted byte updates the state and may produce one result
// depends on zms_pkg
`default_nettype none

module zms_parse_core import zms_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     item_fire,
    input  wire zms_in_t  item,
    output logic          res_emit,
    output zms_out_t      res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  free_reg, free_next;
    logic        in_value_reg, in_value_next;
    logic [31:0] pairs_reg, pairs_next;

    logic        len_done;
    logic [31:0] len_val;
    logic [7:0]  b;

    assign b = item.data_byte;

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        free_next     = free_reg;
        in_value_next = in_value_reg;
        pairs_next    = pairs_reg;
        len_done      = 1'b0;
        len_val       = '0;
        res_emit      = 1'b0;
        res           = '0;

        if (item.start_map) begin
            phase_next    = PH_PREFIX;
            acc_next      = '0;
            idx_next      = '0;
            rem_next      = '0;
            free_next     = '0;
            in_value_next = 1'b0;
            pairs_next    = '0;
        end else begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (b == END_BYTE && !in_value_reg) begin
                        res_emit       = 1'b1;
                        res.map_end    = 1'b1;
                        res.pair_count = pairs_reg;
                        phase_next     = PH_DONE;
                    end else if (b == END_BYTE || b == BAD_PREFIX) begin
                        res_emit       = 1'b1;
                        res.error_code = ERR_BAD_PREFIX;
                        res.pair_count = pairs_reg;
                        phase_next     = PH_IDLE;
                        in_value_next  = 1'b0;
                    end else if (b == BIG_PREFIX) begin
                        acc_next   = '0;
                        idx_next   = '0;
                        phase_next = PH_LEN_EXT;
                    end else begin
                        len_done = 1'b1;
                        len_val  = {24'd0, b};
                    end
                end
                PH_LEN_EXT: begin
                    acc_next[{idx_reg, 3'b000} +: 8] = acc_reg[{idx_reg, 3'b000} +: 8] | b;
                    if (idx_reg == 2'd3) begin
                        idx_next = '0;
                        len_done = 1'b1;
                        len_val  = acc_next;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_FREE_COUNT: begin
                    free_next = b;
                    if (rem_reg == '0) begin
                        pairs_next         = pairs_reg + 32'd1;
                        in_value_next      = 1'b0;
                        phase_next         = (b != 8'd0) ? PH_FREE_SKIP : PH_PREFIX;
                        res_emit           = 1'b1;
                        res.is_value       = 1'b1;
                        res.last_of_string = 1'b1;
                        res.empty_string   = 1'b1;
                        res.pair_count     = pairs_next;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == '0) begin
                        if (in_value_reg) begin
                            pairs_next    = pairs_reg + 32'd1;
                            in_value_next = 1'b0;
                            phase_next    = (free_reg != 8'd0) ? PH_FREE_SKIP : PH_PREFIX;
                        end else begin
                            in_value_next = 1'b1;
                            phase_next    = PH_PREFIX;
                        end
                    end
                    res_emit           = 1'b1;
                    res.out_byte       = b;
                    res.is_value       = in_value_reg;
                    res.last_of_string = (rem_next == '0);
                    res.pair_count     = pairs_next;
                end
                PH_FREE_SKIP: begin
                    free_next = free_reg - 8'd1;
                    if (free_next == 8'd0) begin
                        phase_next = PH_PREFIX;
                    end
                end
                PH_DONE: begin
                    res_emit       = 1'b1;
                    res.error_code = ERR_AFTER_END;
                    res.pair_count = pairs_reg;
                end
                PH_IDLE: begin
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (len_done) begin
                rem_next = len_val;
                if (in_value_reg) begin
                    phase_next = PH_FREE_COUNT;
                end else if (len_val == '0) begin
                    res_emit           = 1'b1;
                    res.last_of_string = 1'b1;
                    res.empty_string   = 1'b1;
                    res.pair_count     = pairs_reg;
                    in_value_next      = 1'b1;
                    phase_next         = PH_PREFIX;
                end else begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            acc_reg      <= '0;
            idx_reg      <= '0;
            rem_reg      <= '0;
            free_reg     <= '0;
            in_value_reg <= 1'b0;
            pairs_reg    <= '0;
        end else if (item_fire) begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            idx_reg      <= idx_next;
            rem_reg      <= rem_next;
            free_reg     <= free_next;
            in_value_reg <= in_value_next;
            pairs_reg    <= pairs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/zipmap_stream_parser_unit.sv =====
// zipmap_stream_parser_unit: top level of the zipmap stream parser
// valid/ready byte input, registered result output
// depends on zms_pkg and zms_parse_core
`default_nettype none

// The parser takes one byte of a serialized zipmap per cycle and answers with at
// most one result item per byte, in the cycle after the byte is accepted. Each byte
// passes through the combinational parser state logic into the result
// register; the input is ready whenever that register is empty or being taken
// this cycle, so a byte can be accepted every cycle while results are drained.
// A byte with start_map set begins a new map and gives no result.

module zipmap_stream_parser_unit import zms_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire zms_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output zms_out_t      m_data
);

    logic     item_fire;
    logic     res_emit;
    zms_out_t res;
    logic     m_valid_reg;
    zms_out_t m_data_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign item_fire = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    zms_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (item_fire),
        .item      (s_data),
        .res_emit  (res_emit),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_fire) begin
            m_valid_reg <= res_emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire && res_emit) begin
            m_data_reg <= res;
        end
    end

    // an end result carries no error and no string content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.map_end |->
            m_data.error_code == ERR_OK && !m_data.is_value && !m_data.empty_string)
        else $error("end item with bad fields");

    // an empty string marker is always the last of its string with a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_string |->
            m_data.last_of_string && m_data.out_byte == 8'd0)
        else $error("empty marker malformed");

    // error items carry no content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_OK |->
            m_data.out_byte == 8'd0 && !m_data.last_of_string && !m_data.map_end)
        else $error("error item carries content");

endmodule

`default_nettype wire
